[hdl/cgce_pkg.sv]
// Shared types, constants and the edge slot function of the clique engine.
`timescale 1ns / 1ps
package cgce_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COLOR_BITS_DEF   = 8;

  localparam int MODE_W  = 3;
  localparam int VERT_W  = 6;
  localparam int SLOT_W  = 11;
  localparam int COLOR_W = 8;
  localparam int K_W     = 7;
  localparam int DEG_W   = 6;
  localparam int MASK_W  = 64;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_SET_PAIR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_INDEX = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEGREE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLIQUE    = 3'd4;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_COLOR_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_DEGREE,
    OP_CLIQUE,
    OP_ERROR
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VERT_W-1:0]  vertex_a;
    logic [VERT_W-1:0]  vertex_b;
    logic [SLOT_W-1:0]  edge_index;
    logic [COLOR_W-1:0] color;
    logic [K_W-1:0]     clique_size;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [DEG_W-1:0]   degree;
    logic               found;
    logic [MASK_W-1:0]  clique_mask;
    logic               error;
  } result_t;

  // classified command handed from the front to the back
  typedef struct packed {
    op_e                op;
    logic [SLOT_W-1:0]  slot;
    logic [VERT_W-1:0]  vertex;
    logic [COLOR_W-1:0] color;
    logic [K_W-1:0]     k;
  } cmd_t;

  // triangular slot of the pair lo < hi on n vertices
  function automatic logic [SLOT_W-1:0] slot_of(logic [VERT_W-1:0] lo,
                                                logic [VERT_W-1:0] hi,
                                                logic [K_W-1:0] n);
    logic [12:0] prod;
    logic [12:0] tri_n;
    logic [12:0] s;
    prod  = 13'(lo) * 13'(n);
    tri_n = ((13'(lo) + 13'd1) * (13'(lo) + 13'd2)) >> 1;
    s     = prod + 13'(hi) - tri_n;
    return s[SLOT_W-1:0];
  endfunction

endpackage

[hdl/cgce_front.sv]
// Front end: takes items and classifies them into commands.
`timescale 1ns / 1ps
module cgce_front (
  input  logic                           start_i,
  input  logic                           busy_i,
  input  cgce_pkg::item_t                item_i,
  input  logic [cgce_pkg::K_W-1:0]       vertex_count_i,
  input  logic [cgce_pkg::COLOR_W-1:0]   color_count_i,
  output logic                           push_o,
  output cgce_pkg::cmd_t                 cmd_o
);
  import cgce_pkg::*;

  logic        pair_ok;
  logic        col_ok;
  logic        k_ok;
  logic        idx_ok;
  logic [13:0] slots;
  logic [VERT_W-1:0] lo;
  logic [VERT_W-1:0] hi;

  assign push_o = start_i & ~busy_i;

  always_comb begin
    pair_ok = (K_W'(item_i.vertex_a) < vertex_count_i) &&
              (K_W'(item_i.vertex_b) < vertex_count_i) &&
              (item_i.vertex_a != item_i.vertex_b);
    col_ok  = item_i.color < color_count_i;
    k_ok    = (item_i.clique_size != '0) && (item_i.clique_size <= vertex_count_i);
    slots   = (14'(vertex_count_i) * (14'(vertex_count_i) - 14'd1)) >> 1;
    idx_ok  = 14'(item_i.edge_index) < slots;
    lo      = (item_i.vertex_a < item_i.vertex_b) ? item_i.vertex_a : item_i.vertex_b;
    hi      = (item_i.vertex_a < item_i.vertex_b) ? item_i.vertex_b : item_i.vertex_a;

    cmd_o        = '0;
    cmd_o.op     = OP_ERROR;
    cmd_o.vertex = item_i.vertex_a;
    cmd_o.color  = item_i.color;
    cmd_o.k      = item_i.clique_size;
    cmd_o.slot   = slot_of(lo, hi, vertex_count_i);
    case (item_i.mode)
      MODE_SET_PAIR: begin
        if (pair_ok && col_ok) cmd_o.op = OP_WRITE;
      end
      MODE_SET_INDEX: begin
        cmd_o.slot = item_i.edge_index;
        if (idx_ok && col_ok) cmd_o.op = OP_WRITE;
      end
      MODE_READ: begin
        if (pair_ok) cmd_o.op = OP_READ;
      end
      MODE_DEGREE: begin
        if ((K_W'(item_i.vertex_a) < vertex_count_i) && col_ok) cmd_o.op = OP_DEGREE;
      end
      MODE_CLIQUE: begin
        if (k_ok && col_ok) cmd_o.op = OP_CLIQUE;
      end
      default: begin
        cmd_o.op = OP_ERROR;
      end
    endcase
  end

endmodule

[hdl/cgce_queue.sv]
// Short command queue between front and back.
`timescale 1ns / 1ps
module cgce_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cgce_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           vld_o,
  output logic           full_o,
  output cgce_pkg::cmd_t cmd_o
);
  import cgce_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign vld_o   = cnt_q != '0;
  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + (PW+1)'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - (PW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

[hdl/cgce_back.sv]
// Back end: edge color store, degree walk and clique search engine.
`timescale 1ns / 1ps
module cgce_back #(
  parameter int MAX_VERTICES = cgce_pkg::MAX_VERTICES_DEF,
  parameter int COLOR_BITS   = cgce_pkg::COLOR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_vld_i,
  input  cgce_pkg::cmd_t           q_cmd_i,
  output logic                     q_pop_o,
  input  logic [cgce_pkg::K_W-1:0] vertex_count_i,
  output logic                     clearing_o,
  output logic                     done_o,
  output cgce_pkg::result_t        result_o
);
  import cgce_pkg::*;

  localparam int MV         = MAX_VERTICES;
  localparam int VW         = $clog2(MAX_VERTICES);
  localparam int EDGE_SLOTS = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int SW         = $clog2(EDGE_SLOTS);
  localparam int CW         = COLOR_BITS;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_RD_WAIT  = 4'd2;
  localparam logic [3:0] S_WALK     = 4'd3;
  localparam logic [3:0] S_SR_INIT  = 4'd4;
  localparam logic [3:0] S_SR_EVAL  = 4'd5;
  localparam logic [3:0] S_SR_DEC   = 4'd6;
  localparam logic [3:0] S_SR_ADJ   = 4'd7;
  localparam logic [3:0] S_SR_POP   = 4'd8;

  logic [CW-1:0]    edge_mem [EDGE_SLOTS];
  logic [MV-1:0]    adj_mem  [MV];
  logic [MV+VW-1:0] stk_mem  [MV];

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] clr_addr_q, clr_addr_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;
  cmd_t          cmd_q, cmd_d;
  logic [VW-1:0] walk_v_q, walk_v_d;
  logic [VW-1:0] walk_w_q, walk_w_d;
  logic          walk_end_q, walk_end_d;
  logic          walk_build_q, walk_build_d;
  logic          p_vld_q, p_vld_d;
  logic [VW-1:0] p_w_q, p_v_q;
  logic          p_self_q, p_last_q;
  logic [VW-1:0] deg_q, deg_d;
  logic [MV-1:0] row_q, row_d;
  logic [MV-1:0] chosen_q, chosen_d;
  logic [MV-1:0] cand_q, cand_d;
  logic [K_W-1:0] count_q, count_d;
  logic [K_W-1:0] pop_q, pop_d;
  logic [VW-1:0]  low_q, low_d;

  logic [CW-1:0]    rd_q;
  logic [MV-1:0]    adj_rd_q;
  logic [MV+VW-1:0] stk_rd_q;

  logic          walk_act, w_self, w_last, v_last, hit;
  logic [VW-1:0] w_lo, w_hi;
  logic [SLOT_W-1:0] walk_slot;
  logic [SW-1:0] rd_addr, mem_waddr;
  logic          rd_en, mem_we;
  logic [CW-1:0] mem_wdata;
  logic [MV-1:0] row_hit, all_n, cand_rm, low_bit, above_low;
  logic [K_W-1:0] pop_c, count_m1;
  logic [VW-1:0]  low_c;
  logic           adj_re, stk_re, stk_we;
  logic [K_W:0]   bound;

  assign clearing_o = state_q == S_CLEAR;
  assign done_o     = done_q;
  assign result_o   = res_q;

  // walk address and pipeline tag
  always_comb begin
    walk_act  = (state_q == S_WALK) && !walk_end_q;
    w_self    = walk_v_q == walk_w_q;
    w_lo      = (walk_v_q < walk_w_q) ? walk_v_q : walk_w_q;
    w_hi      = (walk_v_q < walk_w_q) ? walk_w_q : walk_v_q;
    walk_slot = slot_of(VERT_W'(w_lo), VERT_W'(w_hi), vertex_count_i);
    w_last    = K_W'(walk_w_q) == vertex_count_i - K_W'(1);
    v_last    = !walk_build_q || (K_W'(walk_v_q) == vertex_count_i - K_W'(1));
    hit       = p_vld_q && !p_self_q && (rd_q == cmd_q.color[CW-1:0]);
    row_hit   = row_q | (hit ? (MV'(1) << p_w_q) : '0);
  end

  // search helpers
  always_comb begin
    pop_c = '0;
    for (int i = 0; i < MV; i++) pop_c = pop_c + K_W'(cand_q[i]);
    low_c = '0;
    for (int i = MV - 1; i >= 0; i--) begin
      if (cand_q[i]) low_c = VW'(i);
    end
    for (int i = 0; i < MV; i++) all_n[i] = K_W'(i) < vertex_count_i;
    low_bit   = MV'(1) << low_q;
    above_low = ({MV{1'b1}} << low_q) << 1;
    cand_rm   = cand_q & ~low_bit;
    count_m1  = count_q - K_W'(1);
    bound     = {1'b0, count_q} + {1'b0, pop_q};
  end

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    done_d       = 1'b0;
    res_d        = res_q;
    cmd_d        = cmd_q;
    walk_v_d     = walk_v_q;
    walk_w_d     = walk_w_q;
    walk_end_d   = walk_end_q;
    walk_build_d = walk_build_q;
    p_vld_d      = walk_act;
    deg_d        = deg_q;
    row_d        = row_q;
    chosen_d     = chosen_q;
    cand_d       = cand_q;
    count_d      = count_q;
    pop_d        = pop_q;
    low_d        = low_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = q_cmd_i.slot[SW-1:0];
    mem_wdata    = q_cmd_i.color[CW-1:0];
    rd_en        = walk_act;
    rd_addr      = w_self ? '0 : walk_slot[SW-1:0];
    adj_re       = 1'b0;
    stk_re       = 1'b0;
    stk_we       = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + SW'(1);
        if (clr_addr_q == SW'(EDGE_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        rd_addr = q_cmd_i.slot[SW-1:0];
        if (q_vld_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          case (q_cmd_i.op)
            OP_WRITE: begin
              mem_we = 1'b1;
              done_d = 1'b1;
              res_d  = '0;
            end
            OP_READ: begin
              rd_en   = 1'b1;
              state_d = S_RD_WAIT;
            end
            OP_DEGREE: begin
              walk_v_d     = q_cmd_i.vertex[VW-1:0];
              walk_w_d     = '0;
              walk_end_d   = 1'b0;
              walk_build_d = 1'b0;
              deg_d        = '0;
              state_d      = S_WALK;
            end
            OP_CLIQUE: begin
              walk_v_d     = '0;
              walk_w_d     = '0;
              walk_end_d   = 1'b0;
              walk_build_d = 1'b1;
              row_d        = '0;
              state_d      = S_WALK;
            end
            default: begin
              done_d      = 1'b1;
              res_d       = '0;
              res_d.error = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        done_d           = 1'b1;
        res_d            = '0;
        res_d.read_color = COLOR_W'(rd_q);
        state_d          = S_IDLE;
      end
      S_WALK: begin
        if (walk_act) begin
          if (w_last) begin
            walk_w_d = '0;
            if (v_last) walk_end_d = 1'b1;
            else walk_v_d = walk_v_q + VW'(1);
          end else begin
            walk_w_d = walk_w_q + VW'(1);
          end
        end
        if (hit) deg_d = deg_q + VW'(1);
        row_d = (p_vld_q && p_last_q) ? '0 : row_hit;
        if (walk_end_q && !p_vld_q) begin
          if (walk_build_q) begin
            state_d = S_SR_INIT;
          end else begin
            done_d       = 1'b1;
            res_d        = '0;
            res_d.degree = DEG_W'(deg_q);
            state_d      = S_IDLE;
          end
        end
      end
      S_SR_INIT: begin
        chosen_d = '0;
        count_d  = '0;
        cand_d   = all_n;
        state_d  = S_SR_EVAL;
      end
      S_SR_EVAL: begin
        if (count_q == cmd_q.k) begin
          done_d            = 1'b1;
          res_d             = '0;
          res_d.found       = 1'b1;
          res_d.clique_mask = MASK_W'(chosen_q);
          state_d           = S_IDLE;
        end else begin
          pop_d   = pop_c;
          low_d   = low_c;
          state_d = S_SR_DEC;
        end
      end
      S_SR_DEC: begin
        if (pop_q == '0 || bound < {1'b0, cmd_q.k}) begin
          // dead branch: back up one level or give up
          if (count_q == '0) begin
            done_d  = 1'b1;
            res_d   = '0;
            state_d = S_IDLE;
          end else begin
            stk_re  = 1'b1;
            count_d = count_m1;
            state_d = S_SR_POP;
          end
        end else begin
          stk_we   = 1'b1;
          adj_re   = 1'b1;
          cand_d   = cand_rm;
          chosen_d = chosen_q | low_bit;
          count_d  = count_q + K_W'(1);
          state_d  = S_SR_ADJ;
        end
      end
      S_SR_ADJ: begin
        cand_d  = cand_q & adj_rd_q & above_low;
        state_d = S_SR_EVAL;
      end
      S_SR_POP: begin
        cand_d   = stk_rd_q[MV+VW-1:VW];
        chosen_d = chosen_q & ~(MV'(1) << stk_rd_q[VW-1:0]);
        state_d  = S_SR_EVAL;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
      p_vld_q    <= 1'b0;
      walk_end_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      done_q     <= done_d;
      p_vld_q    <= p_vld_d;
      walk_end_q <= walk_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    cmd_q        <= cmd_d;
    walk_v_q     <= walk_v_d;
    walk_w_q     <= walk_w_d;
    walk_build_q <= walk_build_d;
    p_w_q        <= walk_w_q;
    p_v_q        <= walk_v_q;
    p_self_q     <= w_self;
    p_last_q     <= w_last;
    deg_q        <= deg_d;
    row_q        <= row_d;
    chosen_q     <= chosen_d;
    cand_q       <= cand_d;
    count_q      <= count_d;
    pop_q        <= pop_d;
    low_q        <= low_d;
  end

  // edge color store
  always_ff @(posedge clk_i) begin
    if (mem_we) edge_mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_q <= edge_mem[rd_addr];
  end

  // adjacency rows for the chosen color
  always_ff @(posedge clk_i) begin
    if (p_vld_q && walk_build_q && p_last_q) adj_mem[p_v_q] <= row_hit;
    if (adj_re) adj_rd_q <= adj_mem[low_q];
  end

  // search stack: remaining candidates and chosen vertex per level
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[count_q[VW-1:0]] <= {cand_rm, low_q};
    if (stk_re) stk_rd_q <= stk_mem[count_m1[VW-1:0]];
  end

endmodule

[hdl/colored_graph_clique_engine.sv]
// Top level of the edge-colored complete graph clique engine.
`timescale 1ns / 1ps
// Edge-colored complete graph store with a one-colored k-clique search.
// An item is taken at a rising edge with start high and busy low; every
// item yields exactly one result transaction, shown on result_o for one
// cycle with done_o high. The receiver cannot stall, so results are never
// held back. After reset the block runs a clearing pass over the edge
// store, one slot per cycle, and holds busy high meanwhile; register
// writes are taken throughout. A two-entry queue separates the
// classifier from the execution unit, so new items are taken while one
// is still at work until the queue fills. Execution time per item is
// set by the single read port of the edge store: writes and rejected
// items need no edge read, a read needs one, a degree query reads one
// edge per cycle over the n = vertex_count vertices, and a clique search
// first builds the adjacency rows by reading every pair and then runs
// its search steps; the number of steps depends on the colors and can
// be very large. Registers: vertex_count at address 0, color_count at
// address 4; writes are clamped to the legal range.
module colored_graph_clique_engine #(
  parameter int MAX_VERTICES = cgce_pkg::MAX_VERTICES_DEF,
  parameter int COLOR_BITS   = cgce_pkg::COLOR_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cgce_pkg::item_t   item_i,
  output logic              done_o,
  output cgce_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import cgce_pkg::*;

  logic [K_W-1:0]     vcount_q, vcount_d;
  logic [COLOR_W-1:0] ccount_q, ccount_d;
  logic               cfg_we;
  logic [K_W-1:0]     wr_v;
  logic [8:0]         wr_c;
  logic [8:0]         cmax;

  logic  push, q_full, q_vld, q_pop, clearing;
  cmd_t  front_cmd, q_cmd;

  // register port: one register per word, low address bits ignored
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign cmax   = 9'(1 << COLOR_BITS);

  always_comb begin
    wr_v = pwdata[K_W-1:0];
    if (wr_v < K_W'(2)) wr_v = K_W'(2);
    if (wr_v > K_W'(MAX_VERTICES)) wr_v = K_W'(MAX_VERTICES);
    wr_c = {1'b0, pwdata[COLOR_W-1:0]};
    if (wr_c < 9'd2) wr_c = 9'd2;
    if (wr_c > cmax) wr_c = cmax;

    vcount_d = vcount_q;
    ccount_d = ccount_q;
    if (cfg_we) begin
      case (paddr[2])
        REG_VERTEX_COUNT: vcount_d = wr_v;
        REG_COLOR_COUNT:  ccount_d = wr_c[COLOR_W-1:0];
        default:          vcount_d = vcount_q;
      endcase
    end

    case (paddr[2])
      REG_VERTEX_COUNT: prdata = 32'(vcount_q);
      REG_COLOR_COUNT:  prdata = 32'(ccount_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= (MAX_VERTICES < 64) ? K_W'(MAX_VERTICES) : K_W'(64);
      ccount_q <= COLOR_W'(2);
    end else begin
      vcount_q <= vcount_d;
      ccount_q <= ccount_d;
    end
  end

  // no items while the store is being cleared or the queue is full
  assign busy = q_full | clearing;

  cgce_front u_front (
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .vertex_count_i (vcount_q),
    .color_count_i  (ccount_q),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  cgce_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .full_o (q_full),
    .cmd_o  (q_cmd)
  );

  cgce_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COLOR_BITS   (COLOR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_vld_i        (q_vld),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .vertex_count_i (vcount_q),
    .clearing_o     (clearing),
    .done_o         (done_o),
    .result_o       (result_o)
  );

endmodule

[hdl/cgce_checker.sv]
// Port-level checks of the clique engine, bound to the top level.
`timescale 1ns / 1ps
module cgce_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy,
  input logic              done_o,
  input cgce_pkg::result_t result_o
);

  // store clearing keeps items out right after reset
  a_busy_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> busy)
    else $error("busy low right after reset");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.error |->
      result_o.read_color == '0 && result_o.degree == '0 &&
      !result_o.found && result_o.clique_mask == '0)
    else $error("rejected transaction carries data");

  a_mask_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.found |-> result_o.clique_mask == '0)
    else $error("clique mask without found");

  a_found_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.found |->
      result_o.clique_mask != '0 && !result_o.error &&
      result_o.read_color == '0 && result_o.degree == '0)
    else $error("found transaction malformed");

endmodule

bind colored_graph_clique_engine cgce_port_checks u_cgce_checker (.*);

[tb/cgce_checker.sv]
// Result checker for the clique engine: predicts every transaction and compares it.
`timescale 1ns / 1ps
module cgce_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  cgce_pkg::item_t   item_i,
  input  logic              done_o,
  input  cgce_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                results_owed
);
  import cgce_pkg::*;

  localparam int SLOTS = MAX_VERTICES_DEF * (MAX_VERTICES_DEF - 1) / 2;

  logic [COLOR_W-1:0] edge_color [SLOTS];
  int unsigned        n_vert;
  int unsigned        n_colors;
  logic [63:0]        adj_row [MAX_VERTICES_DEF];
  result_t            expected_results [$];

  function automatic int unsigned pair_slot(int unsigned a, int unsigned b);
    int unsigned lo;
    int unsigned hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (lo * n_vert + hi - ((lo + 1) * (lo + 2)) / 2) % SLOTS;
  endfunction

  function automatic logic [63:0] upper_bits(int unsigned v);
    return (v >= 63) ? 64'd0 : (~64'd0 << (v + 1));
  endfunction

  function automatic int unsigned lowest_set(logic [63:0] x);
    int unsigned i;
    i = 0;
    while (i < 63 && !x[i]) i++;
    return i;
  endfunction

  // depth-first walk, smallest vertex first; explicit stack in place of recursion
  function automatic logic first_clique(int unsigned k, output logic [63:0] members);
    logic [63:0] cand [MAX_VERTICES_DEF+1];
    logic [63:0] picked [MAX_VERTICES_DEF+1];
    int unsigned depth;
    int unsigned v;
    logic [63:0] bit_v;
    depth     = 0;
    picked[0] = '0;
    cand[0]   = (n_vert >= 64) ? ~64'd0 : ((64'd1 << n_vert) - 1);
    members   = '0;
    forever begin
      if (depth == k) begin
        members = picked[depth];
        return 1'b1;
      end
      if (cand[depth] == 0 || depth + $countones(cand[depth]) < k) begin
        if (depth == 0) return 1'b0;
        depth--;
      end else begin
        v     = lowest_set(cand[depth]);
        bit_v = 64'd1 << v;
        cand[depth]     &= ~bit_v;
        picked[depth+1] = picked[depth] | bit_v;
        cand[depth+1]   = cand[depth] & adj_row[v] & upper_bits(v);
        depth++;
      end
    end
  endfunction

  function automatic result_t engine_response(item_t it);
    result_t     r;
    int unsigned a, b, idx, col, k, w, v;
    logic        pair_ok, col_ok;
    logic [63:0] m;
    r       = '0;
    a       = it.vertex_a;
    b       = it.vertex_b;
    idx     = it.edge_index;
    col     = it.color;
    k       = it.clique_size;
    pair_ok = a < n_vert && b < n_vert && a != b;
    col_ok  = col < n_colors;
    case (it.mode)
      MODE_SET_PAIR: begin
        if (pair_ok && col_ok) edge_color[pair_slot(a, b)] = it.color;
        else r.error = 1'b1;
      end
      MODE_SET_INDEX: begin
        if (idx < n_vert * (n_vert - 1) / 2 && idx < SLOTS && col_ok)
          edge_color[idx] = it.color;
        else r.error = 1'b1;
      end
      MODE_READ: begin
        if (pair_ok) r.read_color = edge_color[pair_slot(a, b)];
        else r.error = 1'b1;
      end
      MODE_DEGREE: begin
        if (a < n_vert && col_ok) begin
          for (w = 0; w < n_vert; w++)
            if (w != a && edge_color[pair_slot(a, w)] == it.color) r.degree++;
        end else r.error = 1'b1;
      end
      MODE_CLIQUE: begin
        if (k >= 1 && k <= n_vert && col_ok) begin
          for (v = 0; v < n_vert; v++) begin
            adj_row[v] = '0;
            for (w = 0; w < n_vert; w++)
              if (w != v && edge_color[pair_slot(v, w)] == it.color) adj_row[v][w] = 1'b1;
          end
          r.found = first_clique(k, m);
          r.clique_mask = m;
        end else r.error = 1'b1;
      end
      default: r.error = 1'b1;
    endcase
    return r;
  endfunction

  assign results_owed = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      foreach (edge_color[i]) edge_color[i] = '0;
      n_vert     = 64;
      n_colors   = 2;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COLOR_COUNT)
          n_colors = (pwdata[7:0] < 2) ? 2 : pwdata[7:0];
        else
          n_vert = (pwdata[6:0] < 2) ? 2 : (pwdata[6:0] > 64) ? 64 : pwdata[6:0];
      end
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, result_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_o !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, result_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(engine_response(item_i));
    end
  end

endmodule

[tb/colored_graph_clique_engine_test.sv]
// Stimulus and verdict for the clique engine testbench.
`timescale 1ns / 1ps
module colored_graph_clique_engine_test;
  import cgce_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_i = '0;
  logic        done_o;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          results_owed;
  int          quiet_cycles;
  logic        back_to_back;  // phase flag: no gaps between transactions

  // watchdog covers the store clear and the slowest clique search used
  localparam int QUIET_LIMIT = 400000;
  localparam int ITEM_W      = $bits(item_t);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  colored_graph_clique_engine dut (.*);

  cgce_checker chk (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("colored_graph_clique_engine verification failed");
      $finish;
    end
  end

  // APB write: setup phase, then access until pready
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    start   <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one transaction; start stays high across zero-gap transactions
  task automatic issue(item_t it);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (!(start && !busy));
    @(negedge clk_i);
  endtask

  task automatic issue_op(logic [MODE_W-1:0] m, int a, int b, int idx, int col, int k);
    item_t it;
    it.mode        = m;
    it.vertex_a    = VERT_W'(a);
    it.vertex_b    = VERT_W'(b);
    it.edge_index  = SLOT_W'(idx);
    it.color       = COLOR_W'(col);
    it.clique_size = K_W'(k);
    issue(it);
  endtask

  // idle point: all results back, start dropped, then settle
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_graph(int n, int c);
    reg_write(3'd0, n);
    reg_write(3'd4, c);
  endtask

  // mostly legal items with colors from a small palette so cliques exist
  function automatic item_t random_item(int n, int c);
    item_t it;
    int    sel;
    int    top_col;
    it      = item_t'(ITEM_W'({$urandom, $urandom}));
    sel     = $urandom_range(0, 99);
    top_col = (c - 1 < 3) ? c - 1 : 3;
    if ($urandom_range(0, 9) != 0) begin
      it.vertex_a   = VERT_W'($urandom_range(0, n - 1));
      it.vertex_b   = VERT_W'($urandom_range(0, n - 1));
      it.color      = COLOR_W'($urandom_range(0, top_col));
      it.edge_index = SLOT_W'($urandom_range(0, n * (n - 1) / 2 - 1));
    end
    if (sel < 40) it.mode = MODE_SET_PAIR;
    else if (sel < 55) it.mode = MODE_SET_INDEX;
    else if (sel < 70) it.mode = MODE_READ;
    else if (sel < 80) it.mode = MODE_DEGREE;
    else if (sel < 95) it.mode = MODE_CLIQUE;
    else it.mode = MODE_W'($urandom_range(5, 7));
    if (it.mode == MODE_CLIQUE) begin
      // big graphs: only sizes whose search ends fast
      if (n > 16) begin
        case ($urandom_range(0, 5))
          0: it.clique_size = K_W'(1);
          1: it.clique_size = K_W'(2);
          2: it.clique_size = K_W'(3);
          3: it.clique_size = K_W'(n - 1);
          4: it.clique_size = K_W'(n);
          default: it.clique_size = K_W'(n + $urandom_range(1, 127 - n));
        endcase
      end else if ($urandom_range(0, 7) != 0) begin
        it.clique_size = K_W'($urandom_range(0, n + 1));
      end
    end
    return it;
  endfunction

  initial begin
    int phase_n [7] = '{64, 8, 2, 12, 6, 64, 10};
    int phase_c [7] = '{2, 3, 2, 255, 2, 255, 4};
    back_to_back = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every mode, every reject reason
    set_graph(64, 2);
    issue_op(MODE_SET_PAIR, 63, 0, 0, 1, 0);
    issue_op(MODE_SET_INDEX, 0, 0, 2015, 1, 0);
    issue_op(MODE_READ, 0, 63, 0, 0, 0);
    issue_op(MODE_READ, 63, 62, 0, 255, 0);
    issue_op(MODE_DEGREE, 63, 0, 0, 1, 0);
    issue_op(MODE_DEGREE, 0, 0, 0, 0, 0);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 1);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 64);
    issue_op(MODE_CLIQUE, 0, 0, 0, 1, 3);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 0);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 127);
    issue_op(MODE_SET_PAIR, 5, 5, 0, 1, 0);
    issue_op(MODE_SET_PAIR, 1, 2, 0, 2, 0);
    issue_op(MODE_SET_INDEX, 0, 0, 2047, 1, 0);
    issue_op(MODE_SET_INDEX, 0, 0, 2016, 0, 0);
    issue_op(3'd5, 1, 2, 0, 0, 1);
    issue_op(3'd6, 1, 2, 0, 0, 1);
    issue_op(3'd7, 1, 2, 0, 0, 1);
    drain();
    // shrink the graph: vertex and slot limits, stale colors, clamps
    set_graph(5, 255);
    issue_op(MODE_SET_PAIR, 4, 3, 0, 254, 0);
    issue_op(MODE_SET_PAIR, 5, 1, 0, 1, 0);
    issue_op(MODE_SET_INDEX, 0, 0, 10, 1, 0);
    issue_op(MODE_DEGREE, 5, 0, 0, 1, 0);
    drain();
    set_graph(0, 0);
    issue_op(MODE_READ, 4, 3, 0, 0, 0);
    issue_op(MODE_READ, 0, 1, 0, 0, 0);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 2);
    issue_op(MODE_CLIQUE, 0, 0, 0, 0, 3);
    drain();
    set_graph(127, 1);
    issue_op(MODE_CLIQUE, 0, 0, 0, 1, 2);
    drain();

    // random phases over several graph sizes and palettes
    for (int p = 0; p < 7; p++) begin
      set_graph(phase_n[p], phase_c[p]);
      back_to_back = (p % 3 == 2);
      for (int i = 0; i < 62; i++) issue(random_item(phase_n[p], phase_c[p]));
      drain();
    end

    while (results_owed != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("colored_graph_clique_engine verification clean");
    else $display("colored_graph_clique_engine verification failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/cgce_pkg.sv
hdl/cgce_front.sv
hdl/cgce_queue.sv
hdl/cgce_back.sv
hdl/colored_graph_clique_engine.sv
hdl/cgce_checker.sv
tb/cgce_checker.sv
tb/colored_graph_clique_engine_test.sv
